// ----- hw/rtl/udc_pkg.sv -----
`default_nettype none

package udc_pkg;

  localparam int unsigned SecsW   = 39;
  localparam int unsigned YearW   = 15;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;

  localparam int unsigned DaysW   = 23;
  localparam int unsigned SodW    = 17;
  localparam int unsigned CentW   = 8;
  localparam int unsigned Dn2W    = 18;
  localparam int unsigned YocW    = 7;
  localparam int unsigned Dn3W    = 9;
  localparam int unsigned MonIdxW = 4;
  localparam int unsigned RemhW   = 12;

  localparam int unsigned NumStages = 9;

  // seconds per day is 128 * 675
  localparam int unsigned DayLoBits   = 7;
  localparam logic [9:0]  DaySpan     = 10'd675;
  localparam int unsigned DayRecipSh  = 41;
  localparam logic [31:0] DayRecip    = 32'((64'd1 << DayRecipSh) / 64'd675);

  localparam logic [DaysW-1:0] EpochDayNum = 23'd719468;
  localparam logic [DaysW-1:0] CenturyDays = 23'd36524;
  localparam logic [Dn2W-1:0]  YearDays    = 18'd365;
  localparam logic [YearW-1:0] YearsPerCent = 15'd100;
  localparam logic [SodW-1:0]  SecsPerHour = 17'd3600;
  localparam logic [RemhW-1:0] SecsPerMin  = 12'd60;

  // rounded-up reciprocals, exact over the operand range
  localparam int unsigned CentRecipSh = 43;
  localparam logic [25:0] CentRecip =
    26'(((64'd1 << CentRecipSh) + 64'd146097 - 64'd1) / 64'd146097);
  localparam int unsigned YearRecipSh = 30;
  localparam logic [19:0] YearRecip =
    20'(((64'd1 << YearRecipSh) + 64'd1461 - 64'd1) / 64'd1461);
  localparam int unsigned MonRecipSh = 19;
  localparam logic [11:0] MonRecip =
    12'(((64'd1 << MonRecipSh) + 64'd153 - 64'd1) / 64'd153);
  localparam int unsigned HourRecipSh = 29;
  localparam logic [17:0] HourRecip =
    18'(((64'd1 << HourRecipSh) + 64'd3600 - 64'd1) / 64'd3600);
  localparam int unsigned MinRecipSh = 18;
  localparam logic [12:0] MinRecip =
    13'(((64'd1 << MinRecipSh) + 64'd60 - 64'd1) / 64'd60);

  // months counted from march
  localparam logic [MonIdxW-1:0] MonIdxJan = 4'd10;
  localparam logic [MonIdxW-1:0] MonWrap   = 4'd9;
  localparam logic [MonIdxW-1:0] MonShift  = 4'd3;

  function automatic logic [Dn3W-1:0] month_start(input logic [MonIdxW-1:0] mon);
    logic [Dn3W-1:0] res;
    case (mon)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/unix_seconds_to_civil_date_core.sv -----
// throughput: one transaction per cycle while the output is not stalled, set by the 9-stage pipeline that moves as one
// a stalled output holds the whole pipeline; in_ready_o follows out_ready_i while
// the last stage holds a transaction
// reset: asynchronous, active low, clears the stage valid bits only
`default_nettype none

module unix_seconds_to_civil_date_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [udc_pkg::SecsW-1:0]    seconds_since_epoch_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [udc_pkg::YearW-1:0]    year_o,
  output logic [udc_pkg::MonthW-1:0]   month_o,
  output logic [udc_pkg::DayW-1:0]     day_o,
  output logic [udc_pkg::HourW-1:0]    hour_o,
  output logic [udc_pkg::MinW-1:0]     minute_o,
  output logic [udc_pkg::SecW-1:0]     second_o
);
  import udc_pkg::*;

  logic                 en;
  logic [NumStages-1:0] vld_d, vld_q;
  logic [DaysW-1:0]     day_num;
  logic [SodW-1:0]      sod;

  assign en    = ~vld_q[NumStages-1] | out_ready_i;
  assign vld_d = {vld_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  udc_day_split u_day_split (
    .clk_i     (clk_i),
    .en_i      (en),
    .secs_i    (seconds_since_epoch_i),
    .day_num_o (day_num),
    .sod_o     (sod)
  );

  udc_calendar u_calendar (
    .clk_i     (clk_i),
    .en_i      (en),
    .day_num_i (day_num),
    .year_o    (year_o),
    .month_o   (month_o),
    .day_o     (day_o)
  );

  udc_clock u_clock (
    .clk_i    (clk_i),
    .en_i     (en),
    .sod_i    (sod),
    .hour_o   (hour_o),
    .minute_o (minute_o),
    .second_o (second_o)
  );

  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NumStages-1];

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= 4'd1) && (month_o <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (day_o >= 5'd1) && (year_o >= 15'd1970))
    else $error("day or year out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_o <= 5'd23) && (minute_o <= 6'd59) && (second_o <= 6'd59))
    else $error("time of day out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(vld_q) && $stable(year_o) && $stable(second_o))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ----- hw/rtl/udc_day_split.sv -----
`default_nettype none

module udc_day_split (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire  [udc_pkg::SecsW-1:0]    secs_i,
  output logic [udc_pkg::DaysW-1:0]    day_num_o,
  output logic [udc_pkg::SodW-1:0]     sod_o
);
  import udc_pkg::*;

  localparam int unsigned XW = SecsW - DayLoBits;

  // stage 1: approximate quotient by 675
  logic [XW-1:0]        x;
  logic [63:0]          q_prod;
  logic [DaysW-1:0]     q0_d, q0_q, q0_s2_q;
  logic [XW-1:0]        x_q;
  logic [DayLoBits-1:0] lo_d, lo_q, lo_s2_q;

  assign x      = secs_i[SecsW-1:DayLoBits];
  assign lo_d   = secs_i[DayLoBits-1:0];
  assign q_prod = 64'(x) * 64'(DayRecip);
  assign q0_d   = q_prod[63:DayRecipSh];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_q <= q0_d;
      x_q  <= x;
      lo_q <= lo_d;
    end
  end

  // stage 2: remainder, below twice the divisor
  logic [32:0] qm;
  logic [10:0] r0_d, r0_q;

  assign qm   = 33'(q0_q) * 33'(DaySpan);
  assign r0_d = x_q[10:0] - qm[10:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q    <= r0_d;
      q0_s2_q <= q0_q;
      lo_s2_q <= lo_q;
    end
  end

  // stage 3: correction and epoch offset
  logic [DaysW-1:0] days;
  logic [10:0]      r_fix;
  logic [9:0]       r;
  logic [DaysW-1:0] day_num_d, day_num_q;
  logic [SodW-1:0]  sod_d, sod_q;

  always_comb begin
    if (r0_q >= 11'(DaySpan)) begin
      days  = q0_s2_q + 23'd1;
      r_fix = r0_q - 11'(DaySpan);
    end else begin
      days  = q0_s2_q;
      r_fix = r0_q;
    end
  end

  assign r         = r_fix[9:0];
  assign day_num_d = days + EpochDayNum;
  assign sod_d     = {r, lo_s2_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      day_num_q <= day_num_d;
      sod_q     <= sod_d;
    end
  end

  assign day_num_o = day_num_q;
  assign sod_o     = sod_q;

endmodule

`default_nettype wire

// ----- hw/rtl/udc_clock.sv -----
`default_nettype none

module udc_clock (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  wire  [udc_pkg::SodW-1:0]   sod_i,
  output logic [udc_pkg::HourW-1:0]  hour_o,
  output logic [udc_pkg::MinW-1:0]   minute_o,
  output logic [udc_pkg::SecW-1:0]   second_o
);
  import udc_pkg::*;

  // hour
  logic [34:0]      h_prod;
  logic [HourW-1:0] hour_d, hour_q, hour_s5_q, hour_s6_q, hour_s7_q, hour_s8_q, hour_s9_q;
  logic [SodW-1:0]  sod_q;

  assign h_prod = 35'(sod_i) * 35'(HourRecip);
  assign hour_d = h_prod[HourRecipSh+HourW-1:HourRecipSh];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hour_q <= hour_d;
      sod_q  <= sod_i;
    end
  end

  // seconds within the hour
  logic [SodW-1:0]  hm, h_diff;
  logic [RemhW-1:0] remh_d, remh_q, remh_s6_q;

  assign hm     = 17'(hour_q) * SecsPerHour;
  assign h_diff = sod_q - hm;
  assign remh_d = h_diff[RemhW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      remh_q    <= remh_d;
      hour_s5_q <= hour_q;
    end
  end

  // minute
  logic [24:0]     m_prod;
  logic [MinW-1:0] minute_d, minute_q, minute_s7_q, minute_s8_q, minute_s9_q;

  assign m_prod   = 25'(remh_q) * 25'(MinRecip);
  assign minute_d = m_prod[MinRecipSh+MinW-1:MinRecipSh];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      minute_q  <= minute_d;
      remh_s6_q <= remh_q;
      hour_s6_q <= hour_s5_q;
    end
  end

  // second
  logic [RemhW-1:0] mm, m_diff;
  logic [SecW-1:0]  second_d, second_q, second_s8_q, second_s9_q;

  assign mm       = 12'(minute_q) * SecsPerMin;
  assign m_diff   = remh_s6_q - mm;
  assign second_d = m_diff[SecW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      second_q    <= second_d;
      minute_s7_q <= minute_q;
      hour_s7_q   <= hour_s6_q;
    end
  end

  // align with the date path
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      second_s8_q <= second_q;
      minute_s8_q <= minute_s7_q;
      hour_s8_q   <= hour_s7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      second_s9_q <= second_s8_q;
      minute_s9_q <= minute_s8_q;
      hour_s9_q   <= hour_s8_q;
    end
  end

  assign hour_o   = hour_s9_q;
  assign minute_o = minute_s9_q;
  assign second_o = second_s9_q;

endmodule

`default_nettype wire

// ----- hw/rtl/udc_calendar.sv -----
`default_nettype none

module udc_calendar (
  input  wire                         clk_i,
  input  wire                         en_i,
  input  wire  [udc_pkg::DaysW-1:0]   day_num_i,
  output logic [udc_pkg::YearW-1:0]   year_o,
  output logic [udc_pkg::MonthW-1:0]  month_o,
  output logic [udc_pkg::DayW-1:0]    day_o
);
  import udc_pkg::*;

  // 400-year cycle, century index
  logic [DaysW+1:0] cv;
  logic [50:0]      c_prod;
  logic [CentW-1:0] cent_d, cent_q, cent_s5_q;
  logic [DaysW-1:0] dn_q;

  assign cv     = {day_num_i, 2'b11};
  assign c_prod = 51'(cv) * 51'(CentRecip);
  assign cent_d = c_prod[CentRecipSh+CentW-1:CentRecipSh];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cent_q <= cent_d;
      dn_q   <= day_num_i;
    end
  end

  // day within the century
  logic [DaysW-1:0] cent_days, c_diff;
  logic [Dn2W-1:0]  dn2_d, dn2_q, dn2_s6_q;

  assign cent_days = 23'(cent_q) * CenturyDays + 23'(cent_q[CentW-1:2]);
  assign c_diff    = dn_q - cent_days;
  assign dn2_d     = c_diff[Dn2W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dn2_q     <= dn2_d;
      cent_s5_q <= cent_q;
    end
  end

  // year within the century
  logic [Dn2W+1:0]  yv;
  logic [39:0]      y_prod;
  logic [YocW-1:0]  yoc_d, yoc_q;
  logic [CentW-1:0] cent_s6_q;

  assign yv     = {dn2_q, 2'b11};
  assign y_prod = 40'(yv) * 40'(YearRecip);
  assign yoc_d  = y_prod[YearRecipSh+YocW-1:YearRecipSh];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yoc_q     <= yoc_d;
      dn2_s6_q  <= dn2_q;
      cent_s6_q <= cent_s5_q;
    end
  end

  // day within a march-based year, base year
  logic [Dn2W-1:0]  y_days, y_diff;
  logic [Dn3W-1:0]  dn3_d, dn3_q, dn3_s8_q;
  logic [YearW-1:0] ybase_d, ybase_q, ybase_s8_q;

  assign y_days  = 18'(yoc_q) * YearDays + 18'(yoc_q[YocW-1:2]);
  assign y_diff  = dn2_s6_q - y_days;
  assign dn3_d   = y_diff[Dn3W-1:0];
  assign ybase_d = 15'(cent_s6_q) * YearsPerCent + 15'(yoc_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dn3_q   <= dn3_d;
      ybase_q <= ybase_d;
    end
  end

  // month by the 153-day rule
  logic [10:0]        mv;
  logic [22:0]        mo_prod;
  logic [MonIdxW-1:0] mon_d, mon_q;

  assign mv      = {dn3_q, 2'b00} + 11'(dn3_q) + 11'd2;
  assign mo_prod = 23'(mv) * 23'(MonRecip);
  assign mon_d   = mo_prod[MonRecipSh+MonIdxW-1:MonRecipSh];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mon_q      <= mon_d;
      dn3_s8_q   <= dn3_q;
      ybase_s8_q <= ybase_q;
    end
  end

  // day of month, january and february roll into the next year
  logic [Dn3W-1:0]   dom_full;
  logic [DayW-1:0]   day_d, day_q;
  logic [MonthW-1:0] month_d, month_q;
  logic [YearW-1:0]  year_d, year_q;

  assign dom_full = dn3_s8_q - month_start(mon_q) + 9'd1;
  assign day_d    = dom_full[DayW-1:0];

  always_comb begin
    if (mon_q >= MonIdxJan) begin
      month_d = mon_q - MonWrap;
      year_d  = ybase_s8_q + 15'd1;
    end else begin
      month_d = mon_q + MonShift;
      year_d  = ybase_s8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

`default_nettype wire
